// ===== rtl/scae_pkg.sv =====
package scae_pkg;

    // operation codes
    localparam logic [1:0] OP_ENCODE     = 2'd0;
    localparam logic [1:0] OP_LOAD_REF   = 2'd1;
    localparam logic [1:0] OP_RESET_STEP = 2'd2;

    // coding modes; the fourth code runs as 2-bit
    localparam logic [1:0] MODE_4BIT   = 2'd0;
    localparam logic [1:0] MODE_2P6BIT = 2'd1;
    localparam logic [1:0] MODE_2BIT   = 2'd2;

    localparam logic [2:0] TOP_4BIT   = 3'd3;
    localparam logic [2:0] TOP_2P6BIT = 3'd4;
    localparam logic [2:0] TOP_2BIT   = 3'd5;

    localparam logic [7:0] PRED_RESET = 8'd128;
    localparam logic [7:0] PRED_MAX   = 8'hFF;

    // step adjustments, two's complement
    localparam logic [1:0] DN = 2'b11;
    localparam logic [1:0] KP = 2'b00;
    localparam logic [1:0] UP = 2'b01;

    localparam logic [5:0] MAG4 [0:3][0:7] = '{
        '{6'd0, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7},
        '{6'd1, 6'd3,  6'd5,  6'd7,  6'd9,  6'd11, 6'd13, 6'd15},
        '{6'd2, 6'd6,  6'd10, 6'd14, 6'd18, 6'd22, 6'd26, 6'd30},
        '{6'd4, 6'd12, 6'd20, 6'd28, 6'd36, 6'd44, 6'd52, 6'd60}
    };
    localparam logic [1:0] ADJ4 [0:3][0:7] = '{
        '{KP, KP, KP, KP, KP, UP, UP, UP},
        '{DN, KP, KP, KP, KP, UP, UP, UP},
        '{DN, KP, KP, KP, KP, UP, UP, UP},
        '{DN, KP, KP, KP, KP, KP, KP, KP}
    };
    localparam logic [5:0] MAG26 [0:4][0:3] = '{
        '{6'd0, 6'd1,  6'd2,  6'd3},
        '{6'd1, 6'd3,  6'd5,  6'd7},
        '{6'd2, 6'd6,  6'd10, 6'd14},
        '{6'd4, 6'd12, 6'd20, 6'd28},
        '{6'd5, 6'd15, 6'd25, 6'd35}
    };
    localparam logic [1:0] ADJ26 [0:4][0:3] = '{
        '{KP, KP, KP, UP},
        '{DN, KP, KP, UP},
        '{DN, KP, KP, UP},
        '{DN, KP, KP, UP},
        '{DN, KP, KP, KP}
    };
    localparam logic [5:0] MAG2 [0:5][0:1] = '{
        '{6'd0,  6'd1},
        '{6'd1,  6'd3},
        '{6'd2,  6'd6},
        '{6'd4,  6'd12},
        '{6'd8,  6'd24},
        '{6'd16, 6'd48}
    };
    localparam logic [1:0] ADJ2 [0:5][0:1] = '{
        '{KP, UP},
        '{DN, UP},
        '{DN, UP},
        '{DN, UP},
        '{DN, UP},
        '{DN, KP}
    };

endpackage

// ===== rtl/scae_if.sv =====
interface scae_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] sample;
    logic       narrow_slot;

    modport source (output valid, output operation, output sample, output narrow_slot,
                    input ready);
    modport sink (input valid, input operation, input sample, input narrow_slot,
                  output ready);
endinterface

interface scae_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] code;

    modport source (output valid, output code, input ready);
    modport sink (input valid, input code, output ready);
endinterface

interface scae_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] coding_mode;

    modport source (output valid, output coding_mode, input ready);
    modport sink (input valid, input coding_mode, output ready);
endinterface

// ===== rtl/sound_card_adpcm_encoder.sv =====
// ADPCM encoder, 8-bit unsigned samples to 4-bit, 2.6-bit or 2-bit codes.
//
// Channels:
//   samples : input words {operation, sample, narrow_slot}. Operation 0 encodes
//             a sample and yields one code word; 1 loads a reference byte and
//             zeroes the step; 2 sets the step to the top of the mode's table; 3 does nothing.
//   codes   : output words {code}, one per encoded sample, in order.
//   cfg     : writes coding_mode; always ready. Write it only while idle.
// Timing: a word accepted on samples is held in the input register; its code is
// loaded into the result register when the word advances and is offered on
// codes from there. One word per cycle is sustained while codes is not stalled;
// the rate is set by the predictor/step update loop through the state
// registers.
// Stall: while codes is held off, the result register keeps its code and the
// input register holds the next word; samples.ready drops once both are full.
// Words that make no code move on even while codes is stalled.
// Reset: predictor 128, step 0, carried error 0, last code 0, mode 4-bit,
// both registers empty.
module sound_card_adpcm_encoder
    import scae_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    scae_in_if.sink      samples,
    scae_out_if.source   codes,
    scae_cfg_if.sink     cfg
);

    logic       in_valid_reg;
    logic [1:0] op_reg;
    logic [7:0] sample_reg;
    logic       narrow_reg;

    logic       out_valid_reg;
    logic [3:0] code_reg;

    logic [1:0] coding_mode_reg;
    logic [7:0] predictor_reg;
    logic [2:0] step_index_reg;
    logic [6:0] carried_error_reg;
    logic [1:0] last_code_reg;

    logic       advance;
    logic       accept;

    logic [2:0]        top;
    logic [2:0]        step_eff;
    logic [7:0]        diff8;
    logic              use_err;
    logic signed [9:0] d_sum;
    logic [2:0]        shamt;
    logic signed [9:0] q;
    logic              neg;
    logic [9:0]        q_abs;
    logic [2:0]        ebits;
    logic [6:0]        err_mask;
    logic [2:0]        mag3;
    logic [1:0]        mag2b;
    logic              mag1;
    logic [2:0]        code26;
    logic [5:0]        amount;
    logic [1:0]        adj;
    logic [3:0]        code_next;
    logic [1:0]        last_code_next;
    logic signed [9:0] pred_sum;
    logic [7:0]        predictor_next;
    logic signed [3:0] step_sum;
    logic [2:0]        step_next;
    logic [6:0]        carried_error_next;

    // an encode word needs room in the result register; others just retire
    assign advance = in_valid_reg &&
                     (op_reg != OP_ENCODE || !out_valid_reg || codes.ready);
    assign samples.ready = !in_valid_reg || advance;
    assign accept = samples.valid && samples.ready;

    assign codes.valid = out_valid_reg;
    assign codes.code  = code_reg;
    assign cfg.ready   = 1'b1;

    always_comb
    begin
        unique case (coding_mode_reg)
            MODE_4BIT:   top = TOP_4BIT;
            MODE_2P6BIT: top = TOP_2P6BIT;
            default:     top = TOP_2BIT;
        endcase
        step_eff = (step_index_reg > top) ? top : step_index_reg;

        unique case (coding_mode_reg)
            MODE_4BIT:   use_err = (step_eff < 3'd3);
            MODE_2P6BIT: use_err = (step_eff < 3'd2);
            default:     use_err = (step_eff == 3'd0);
        endcase

        // wrapped 8-bit difference, doubled
        diff8 = sample_reg - predictor_reg;
        d_sum = $signed({diff8[7], diff8, 1'b0})
              + $signed(use_err ? {3'b000, carried_error_reg} : 10'd0);
        shamt = step_eff + 3'd1;
        q     = d_sum >>> shamt;
        neg   = q[9];
        q_abs = neg ? $unsigned(-q) : $unsigned(q);

        unique case (coding_mode_reg)
            MODE_4BIT:   ebits = step_eff + 3'd1;
            MODE_2P6BIT: ebits = step_eff + (narrow_reg ? 3'd2 : 3'd1);
            default:     ebits = step_eff;
        endcase
        err_mask = (7'd1 << ebits) - 7'd1;
        carried_error_next = d_sum[6:0] & err_mask;

        mag3  = (q_abs > 10'd7) ? 3'd7 : q_abs[2:0];
        mag2b = (q_abs > 10'd3) ? 2'd3 : q_abs[1:0];
        // ring suppression: a positive one after code 3 at the top step
        mag1  = (q_abs != 10'd0) &&
                !(step_eff == TOP_2BIT && q_abs == 10'd1 && last_code_reg == 2'd3 && !neg);

        code26 = {neg, mag2b};
        if (narrow_reg)
        begin
            code26 = code26 & 3'b110;
        end

        last_code_next = last_code_reg;
        unique case (coding_mode_reg)
            MODE_4BIT:
            begin
                amount    = MAG4[step_eff[1:0]][mag3];
                adj       = ADJ4[step_eff[1:0]][mag3];
                code_next = {neg, mag3};
            end
            MODE_2P6BIT:
            begin
                amount    = MAG26[step_eff][code26[1:0]];
                adj       = ADJ26[step_eff][code26[1:0]];
                code_next = {1'b0, code26};
            end
            default:
            begin
                amount         = MAG2[step_eff][mag1];
                adj            = ADJ2[step_eff][mag1];
                code_next      = {2'b00, neg, mag1};
                last_code_next = {neg, mag1};
            end
        endcase

        pred_sum = $signed({2'b00, predictor_reg})
                 + (neg ? -$signed({4'b0000, amount}) : $signed({4'b0000, amount}));
        if (pred_sum < 0)
        begin
            predictor_next = 8'd0;
        end
        else if (pred_sum > $signed({2'b00, PRED_MAX}))
        begin
            predictor_next = PRED_MAX;
        end
        else
        begin
            predictor_next = pred_sum[7:0];
        end

        step_sum = $signed({1'b0, step_eff}) + $signed({{2{adj[1]}}, adj});
        if (step_sum < 0)
        begin
            step_next = 3'd0;
        end
        else if (step_sum[2:0] > top)
        begin
            step_next = top;
        end
        else
        begin
            step_next = step_sum[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            coding_mode_reg   <= MODE_4BIT;
            predictor_reg     <= PRED_RESET;
            step_index_reg    <= 3'd0;
            carried_error_reg <= 7'd0;
            last_code_reg     <= 2'd0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                coding_mode_reg <= cfg.coding_mode;
            end

            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance && op_reg == OP_ENCODE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (codes.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                unique case (op_reg)
                    OP_ENCODE:
                    begin
                        predictor_reg     <= predictor_next;
                        step_index_reg    <= step_next;
                        carried_error_reg <= carried_error_next;
                        last_code_reg     <= last_code_next;
                    end
                    OP_LOAD_REF:
                    begin
                        predictor_reg  <= sample_reg;
                        step_index_reg <= 3'd0;
                    end
                    OP_RESET_STEP:
                    begin
                        step_index_reg <= top;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= samples.operation;
            sample_reg <= samples.sample;
            narrow_reg <= samples.narrow_slot;
        end
        if (advance && op_reg == OP_ENCODE)
        begin
            code_reg <= code_next;
        end
    end

    // step never leaves the largest table
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_index_reg <= TOP_2BIT)
        else $error("step index out of range");

    // an encode word always lands in the result register
    a_encode_out: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && op_reg == OP_ENCODE) |=> out_valid_reg)
        else $error("encoded word lost");

    // words without a code never create one
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && op_reg != OP_ENCODE && (!out_valid_reg || codes.ready))
        |=> !out_valid_reg)
        else $error("code word invented");

    // a held input word is not dropped
    a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input word dropped");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
module tb;
    import scae_pkg::*;

    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam logic [1:0] MODE_2BIT_ALT = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int WORDS_PER_PHASE = 154;

    // 2-bit follows 4-bit and 2.6-bit follows 2-bit, so a leftover step gets saturated
    localparam logic [1:0] MODE_ORDER [4] = '{MODE_4BIT, MODE_2BIT, MODE_2P6BIT, MODE_2BIT_ALT};

    localparam int STEP4_MAG [4][8] = '{
        '{0, 1, 2, 3, 4, 5, 6, 7},
        '{1, 3, 5, 7, 9, 11, 13, 15},
        '{2, 6, 10, 14, 18, 22, 26, 30},
        '{4, 12, 20, 28, 36, 44, 52, 60}
    };
    localparam int STEP4_ADJ [4][8] = '{
        '{0, 0, 0, 0, 0, 1, 1, 1},
        '{-1, 0, 0, 0, 0, 1, 1, 1},
        '{-1, 0, 0, 0, 0, 1, 1, 1},
        '{-1, 0, 0, 0, 0, 0, 0, 0}
    };
    localparam int STEP26_MAG [5][4] = '{
        '{0, 1, 2, 3}, '{1, 3, 5, 7}, '{2, 6, 10, 14}, '{4, 12, 20, 28}, '{5, 15, 25, 35}
    };
    localparam int STEP26_ADJ [5][4] = '{
        '{0, 0, 0, 1}, '{-1, 0, 0, 1}, '{-1, 0, 0, 1}, '{-1, 0, 0, 1}, '{-1, 0, 0, 0}
    };
    localparam int STEP2_MAG [6][2] = '{
        '{0, 1}, '{1, 3}, '{2, 6}, '{4, 12}, '{8, 24}, '{16, 48}
    };
    localparam int STEP2_ADJ [6][2] = '{
        '{0, 1}, '{-1, 1}, '{-1, 1}, '{-1, 1}, '{-1, 1}, '{-1, 0}
    };

    class encoder_tracker;
        logic [3:0] pending_codes[$];
        logic [1:0] mode;
        logic [7:0] pred;
        logic [2:0] step;
        logic [6:0] carry;
        logic [1:0] last_code;
        int errors;

        function new();
            mode = MODE_4BIT;
            pred = 8'd128;
            step = 3'd0;
            carry = 7'd0;
            last_code = 2'd0;
            errors = 0;
        endfunction

        function void apply_update(int amount, bit neg, int adj, logic [2:0] top);
            int p;
            int s;
            p = int'(pred) + (neg ? -amount : amount);
            if (p < 0) p = 0;
            if (p > 255) p = 255;
            pred = p[7:0];
            s = int'(step) + adj;
            if (s < 0) s = 0;
            if (s > int'(top)) s = int'(top);
            step = s[2:0];
        endfunction

        function void note_word(logic [1:0] op, logic [7:0] smp, logic narrow);
            logic [2:0] top;
            logic [7:0] diff;
            logic [3:0] code;
            int d;
            int q;
            int mag;
            int s;
            int nbits;
            bit neg;
            top = (mode == MODE_4BIT) ? 3'd3 : (mode == MODE_2P6BIT) ? 3'd4 : 3'd5;
            if (op == OP_LOAD_REF) begin
                pred = smp;
                step = 3'd0;
                return;
            end
            if (op == OP_RESET_STEP) begin
                step = top;
                return;
            end
            if (op != OP_ENCODE) return;
            if (step > top) step = top;
            s = int'(step);
            diff = smp - pred;
            d = 2 * int'($signed(diff));
            if (mode == MODE_4BIT) begin
                if (s < 3) d += int'(carry);
                carry = 7'(d & ((1 << (s + 1)) - 1));
                q = d >>> (s + 1);
                neg = q < 0;
                mag = neg ? -q : q;
                if (mag > 7) mag = 7;
                code = {neg, mag[2:0]};
                apply_update(STEP4_MAG[s][mag], neg, STEP4_ADJ[s][mag], top);
            end else if (mode == MODE_2P6BIT) begin
                nbits = s + (narrow ? 2 : 1);
                if (s < 2) d += int'(carry);
                carry = 7'(d & ((1 << nbits) - 1));
                q = d >>> (s + 1);
                neg = q < 0;
                mag = neg ? -q : q;
                if (mag > 3) mag = 3;
                code = {1'b0, neg, mag[1:0]};
                // narrow slot keeps only the top two bits of the code
                if (narrow) code[0] = 1'b0;
                apply_update(STEP26_MAG[s][code[1:0]], code[2], STEP26_ADJ[s][code[1:0]], top);
            end else begin
                if (s == 0) d += int'(carry);
                carry = 7'(d & ((1 << s) - 1));
                q = d >>> (s + 1);
                neg = q < 0;
                mag = neg ? -q : q;
                // ringing: positive step right after a negative full step at the top row
                if (s == 5 && mag == 1 && last_code == 2'd3 && !neg) mag = 0;
                if (mag > 1) mag = 1;
                code = {2'b00, neg, mag[0]};
                last_code = code[1:0];
                apply_update(STEP2_MAG[s][mag], neg, STEP2_ADJ[s][mag], top);
            end
            pending_codes.push_back(code);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_code(logic [3:0] got);
            logic [3:0] want;
            if (pending_codes.size() == 0) begin
                report($sformatf("code %0d with no word pending", got));
            end else begin
                want = pending_codes.pop_front();
                if (got !== want) report($sformatf("code %0d, expected %0d", got, want));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int send_idle;
    int recv_stall;
    int cycles = 0;

    scae_in_if  in_if();
    scae_out_if out_if();
    scae_cfg_if cfg_if();

    encoder_tracker tracker = new();

    sound_card_adpcm_encoder DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (in_if),
        .codes   (out_if),
        .cfg     (cfg_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready) tracker.mode = cfg_if.coding_mode;
            if (in_if.valid && in_if.ready)
                tracker.note_word(in_if.operation, in_if.sample, in_if.narrow_slot);
            if (out_if.valid && out_if.ready) tracker.check_code(out_if.code);
        end
        out_if.ready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send_word(logic [1:0] op, logic [7:0] smp, logic narrow);
        while ($urandom_range(99) < send_idle)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.operation <= op;
        in_if.sample <= smp;
        in_if.narrow_slot <= narrow;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
    endtask

    // drain all codes, then give words that make no code time to leave the pipe
    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_codes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(logic [1:0] m);
        cfg_if.valid <= 1'b1;
        cfg_if.coding_mode <= m;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic random_word();
        logic [1:0] op;
        logic [7:0] smp;
        int pick;
        int offset;
        pick = $urandom_range(99);
        if (pick < 6) op = OP_LOAD_REF;
        else if (pick < 10) op = OP_RESET_STEP;
        else if (pick < 13) op = OP_UNKNOWN;
        else op = OP_ENCODE;
        // mostly samples near the predictor, at every scale, so the step moves both ways
        if ($urandom_range(2) == 0)
            smp = 8'($urandom_range(255));
        else
        begin
            offset = $urandom_range(1 << $urandom_range(7));
            smp = $urandom_range(1) ? tracker.pred + offset[7:0] : tracker.pred - offset[7:0];
        end
        send_word(op, smp, $urandom_range(2) == 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        send_idle = 0;
        recv_stall = 0;
        in_if.valid = 1'b0;
        in_if.operation = OP_ENCODE;
        in_if.sample = 8'd0;
        in_if.narrow_slot = 1'b0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.coding_mode = MODE_4BIT;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        write_mode(MODE_4BIT);
        send_word(OP_ENCODE, 8'd128, 1'b0);
        send_word(OP_ENCODE, 8'd255, 1'b0);
        send_word(OP_ENCODE, 8'd0, 1'b1);
        send_word(OP_ENCODE, 8'd0, 1'b0);
        send_word(OP_UNKNOWN, 8'd255, 1'b1);
        send_word(OP_LOAD_REF, 8'd255, 1'b0);
        send_word(OP_ENCODE, 8'd0, 1'b0);
        send_word(OP_LOAD_REF, 8'd0, 1'b1);
        send_word(OP_ENCODE, 8'd255, 1'b0);
        send_word(OP_RESET_STEP, 8'd0, 1'b0);
        send_word(OP_ENCODE, 8'd200, 1'b0);
        send_word(OP_ENCODE, 8'd60, 1'b0);
        settle();

        write_mode(MODE_2P6BIT);
        send_word(OP_RESET_STEP, 8'd0, 1'b0);
        send_word(OP_ENCODE, 8'd0, 1'b1);
        send_word(OP_ENCODE, 8'd255, 1'b1);
        send_word(OP_ENCODE, 8'd255, 1'b0);
        settle();

        // top-row negative step then a positive one: the second must come out zero
        write_mode(MODE_2BIT);
        send_word(OP_LOAD_REF, 8'd128, 1'b0);
        send_word(OP_RESET_STEP, 8'd0, 1'b0);
        send_word(OP_ENCODE, 8'd110, 1'b0);
        send_word(OP_ENCODE, 8'd120, 1'b0);
        settle();

        for (int phase = 0; phase < 8; phase++)
        begin
            write_mode(MODE_ORDER[phase % 4]);
            case ((phase + phase / 4) % 4)
                0:
                begin
                    send_idle = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle = 65;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle = 0;
                    recv_stall = 65;
                end
                default:
                begin
                    send_idle = 31;
                    recv_stall = 31;
                end
            endcase
            repeat (WORDS_PER_PHASE) random_word();
            settle();
        end

        if (tracker.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/scae_pkg.sv
rtl/scae_if.sv
rtl/sound_card_adpcm_encoder.sv
test/tb.sv
